// ===== hw/rtl/prd_pkg.sv =====
// Package for the perspective ray direction block: shared widths, register
// indexes and the pipeline payload type. No dependencies.
`timescale 1ns / 1ps
package prd_pkg;

  localparam int CompBits   = 16;
  localparam int RegW       = 48;
  localparam int DataW      = 64;
  localparam int AddrW      = 5;
  localparam int MagW       = 30;
  localparam int OutFrac    = 14;
  localparam int OutOne     = 16384;
  localparam int SumW       = 64;
  localparam int RootW      = 32;
  localparam int SqrtSteps  = 32;
  localparam int DivSteps   = 15;
  localparam int DivW       = 47;
  localparam int FrontDepth = 6;
  localparam int Latency    = FrontDepth + SqrtSteps + DivSteps + 1;

  typedef enum logic [1:0] {
    RegCorner = 2'd0,
    RegHstep  = 2'd1,
    RegVstep  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic                 zero;
  } vec_t;

endpackage

// ===== hw/rtl/prd_front.sv =====
// Front pipeline: products, sum, magnitude, common scaling and sum of squares.
// Depends on prd_pkg.
`timescale 1ns / 1ps
module prd_front import prd_pkg::*; #(
  parameter int CB = CompBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [15:0]      u_i,
  input  logic [15:0]      v_i,
  input  logic [RegW-1:0]  corner_i,
  input  logic [RegW-1:0]  hstep_i,
  input  logic [RegW-1:0]  vstep_i,
  output logic             valid_o,
  output logic [SumW-1:0]  sumsq_o,
  output vec_t             vec_o
);

  localparam int DW = CB + 18;
  localparam int LW = $clog2(DW + 1);
  localparam int EW = RegW + 3 * CB;
  localparam int PW = CB + 17;

  logic [EW-1:0] c_ext, h_ext, v_ext;
  logic signed [CB-1:0] c_k [3];
  logic signed [CB-1:0] h_k [3];
  logic signed [CB-1:0] v_k [3];

  assign c_ext = EW'(corner_i);
  assign h_ext = EW'(hstep_i);
  assign v_ext = EW'(vstep_i);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_k[k] = c_ext[k*CB +: CB];
      h_k[k] = h_ext[k*CB +: CB];
      v_k[k] = v_ext[k*CB +: CB];
    end
  end

  // stage A: products
  logic                 va_q;
  logic signed [CB-1:0] ca_q [3];
  logic signed [PW-1:0] ph_q [3];
  logic signed [PW-1:0] pv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      ca_q[k] <= c_k[k];
      ph_q[k] <= $signed({1'b0, u_i}) * h_k[k];
      pv_q[k] <= $signed({1'b0, v_i}) * v_k[k];
    end
  end

  // stage B: sum and magnitude
  logic signed [DW-1:0] d_b [3];
  logic                 vb_q;
  logic [DW-1:0]        mb_q [3];
  logic [2:0]           nb_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_b[k] = (DW'(ca_q[k]) <<< 15) + DW'(ph_q[k]) + DW'(pv_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      nb_q[k] <= d_b[k][DW-1];
      mb_q[k] <= d_b[k][DW-1] ? DW'(-d_b[k]) : DW'(d_b[k]);
    end
  end

  // stage C: bit length of the largest magnitude
  logic [DW-1:0] or_c;
  logic [LW-1:0] len_c;
  logic          vc_q;
  logic [DW-1:0] mc_q [3];
  logic [2:0]    nc_q;
  logic [LW-1:0] lc_q;

  always_comb begin
    or_c  = mb_q[0] | mb_q[1] | mb_q[2];
    len_c = '0;
    for (int i = 0; i < DW; i++) begin
      if (or_c[i]) begin
        len_c = LW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      mc_q[k] <= mb_q[k];
    end
    nc_q <= nb_q;
    lc_q <= len_c;
  end

  // stage D: scale so the top set bit lands at MagW-1
  logic [DW+MagW-1:0] wide_d [3];
  vec_t               vec_d;
  logic               vd_q;
  vec_t               vd_vec_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wide_d[k]    = {mc_q[k], {MagW{1'b0}}} >> lc_q;
      vec_d.mag[k] = wide_d[k][MagW-1:0];
    end
    vec_d.neg  = nc_q;
    vec_d.zero = (lc_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vd_vec_q <= vec_d;
  end

  // stage E: squares
  logic                  ve_q;
  vec_t                  ve_vec_q;
  logic [2*MagW-1:0]     sq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ve_vec_q <= vd_vec_q;
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= vd_vec_q.mag[k] * vd_vec_q.mag[k];
    end
  end

  // stage F: sum of squares
  logic            vf_q;
  vec_t            vf_vec_q;
  logic [SumW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vf_vec_q <= ve_vec_q;
    sum_q    <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
  end

  assign valid_o = vf_q;
  assign sumsq_o = sum_q;
  assign vec_o   = vf_vec_q;

endmodule

// ===== hw/rtl/prd_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on prd_pkg.
`timescale 1ns / 1ps
module prd_sqrt import prd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [SumW-1:0]  sumsq_i,
  input  vec_t             vec_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output vec_t             vec_o
);

  logic            vld_q [SqrtSteps+1];
  logic [SumW-1:0] x_q   [SqrtSteps+1];
  logic [SumW-1:0] r_q   [SqrtSteps+1];
  vec_t            vec_q [SqrtSteps+1];

  assign vld_q[0] = valid_i;
  assign x_q[0]   = sumsq_i;
  assign r_q[0]   = '0;
  assign vec_q[0] = vec_i;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
    localparam int Sh = SumW - 2 - 2 * i;
    logic [SumW-1:0] bv, trial, x_d, r_d;

    always_comb begin
      bv    = SumW'(1) << Sh;
      trial = r_q[i] + bv;
      if (x_q[i] >= trial) begin
        x_d = x_q[i] - trial;
        r_d = (r_q[i] >> 1) + bv;
      end else begin
        x_d = x_q[i];
        r_d = r_q[i] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i+1]   <= x_d;
      r_q[i+1]   <= r_d;
      vec_q[i+1] <= vec_q[i];
    end
  end

  assign valid_o = vld_q[SqrtSteps];
  assign root_o  = r_q[SqrtSteps][RootW-1:0];
  assign vec_o   = vec_q[SqrtSteps];

endmodule

// ===== hw/rtl/prd_div.sv =====
// Pipelined rounding divider: three lanes, one quotient bit per stage.
// Depends on prd_pkg.
`timescale 1ns / 1ps
module prd_div import prd_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [RootW-1:0]               root_i,
  input  vec_t                           vec_i,
  output logic                           valid_o,
  output logic [2:0][DivSteps-1:0]       quot_o,
  output logic [2:0]                     neg_o,
  output logic                           zero_o
);

  logic                         vld_q [DivSteps+1];
  logic [RootW-1:0]             n_q   [DivSteps+1];
  logic [2:0][DivW-1:0]         rem_q [DivSteps+1];
  logic [2:0][DivSteps-1:0]     q_q   [DivSteps+1];
  logic [2:0]                   neg_q [DivSteps+1];
  logic                         zr_q  [DivSteps+1];

  assign vld_q[0] = valid_i;
  assign n_q[0]   = root_i;
  assign q_q[0]   = '0;
  assign neg_q[0] = vec_i.neg;
  assign zr_q[0]  = vec_i.zero;

  for (genvar k = 0; k < 3; k++) begin : g_rem0
    assign rem_q[0][k] = DivW'({vec_i.mag[k], {OutFrac{1'b0}}}) + DivW'(root_i >> 1);
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    localparam int B = DivSteps - 1 - i;
    logic [DivW-1:0]              nb;
    logic [2:0][DivW-1:0]         rem_d;
    logic [2:0][DivSteps-1:0]     q_d;

    always_comb begin
      nb = DivW'(n_q[i]) << B;
      for (int k = 0; k < 3; k++) begin
        rem_d[k] = rem_q[i][k];
        q_d[k]   = q_q[i][k];
        if (rem_q[i][k] >= nb) begin
          rem_d[k]  = rem_q[i][k] - nb;
          q_d[k][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[i+1]   <= n_q[i];
      rem_q[i+1] <= rem_d;
      q_q[i+1]   <= q_d;
      neg_q[i+1] <= neg_q[i];
      zr_q[i+1]  <= zr_q[i];
    end
  end

  assign valid_o = vld_q[DivSteps];
  assign quot_o  = q_q[DivSteps];
  assign neg_o   = neg_q[DivSteps];
  assign zero_o  = zr_q[DivSteps];

endmodule

// ===== hw/rtl/perspective_ray_direction.sv =====
// Pipeline: each start_i transfer passes the front stages, the 32-stage square root,
// the 15-stage divider and an output register, then strobes valid_o.
// Throughput: one item per cycle; busy_o stays low and the receiver cannot stall.
// Reset: asynchronous, active low; clears all pipeline valid bits and the
// three configuration registers to zero.
`timescale 1ns / 1ps
module perspective_ray_direction import prd_pkg::*; #(
  parameter int COMPONENT_BITS = CompBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [15:0]       screen_u_i,
  input  logic [15:0]       screen_v_i,
  output logic              valid_o,
  output logic signed [15:0] ray_x_o,
  output logic signed [15:0] ray_y_o,
  output logic signed [15:0] ray_z_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  logic [RegW-1:0] corner_q, hstep_q, vstep_q;
  reg_idx_e        idx;
  logic            wr_en;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign idx    = reg_idx_e'(paddr[AddrW-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      hstep_q  <= '0;
      vstep_q  <= '0;
    end else if (wr_en) begin
      case (idx)
        RegCorner: corner_q <= pwdata[RegW-1:0];
        RegHstep:  hstep_q  <= pwdata[RegW-1:0];
        RegVstep:  vstep_q  <= pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegCorner: prdata = DataW'(corner_q);
      RegHstep:  prdata = DataW'(hstep_q);
      RegVstep:  prdata = DataW'(vstep_q);
      default:   prdata = '0;
    endcase
  end

  logic            f_valid;
  logic [SumW-1:0] f_sumsq;
  vec_t            f_vec;

  prd_front #(.CB(COMPONENT_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i && !busy_o),
    .u_i      (screen_u_i),
    .v_i      (screen_v_i),
    .corner_i (corner_q),
    .hstep_i  (hstep_q),
    .vstep_i  (vstep_q),
    .valid_o  (f_valid),
    .sumsq_o  (f_sumsq),
    .vec_o    (f_vec)
  );

  logic             s_valid;
  logic [RootW-1:0] s_root;
  vec_t             s_vec;

  prd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .sumsq_i (f_sumsq),
    .vec_i   (f_vec),
    .valid_o (s_valid),
    .root_o  (s_root),
    .vec_o   (s_vec)
  );

  logic                     d_valid;
  logic [2:0][DivSteps-1:0] d_quot;
  logic [2:0]               d_neg;
  logic                     d_zero;

  prd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .root_i  (s_root),
    .vec_i   (s_vec),
    .valid_o (d_valid),
    .quot_o  (d_quot),
    .neg_o   (d_neg),
    .zero_o  (d_zero)
  );

  logic [2:0][15:0] ray_d;
  logic [2:0][15:0] ray_q;
  logic             valid_q;
  logic [15:0]      qc;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc = 16'(d_quot[k]);
      if (qc > 16'(OutOne)) begin
        qc = 16'(OutOne);
      end
      if (d_zero) begin
        ray_d[k] = '0;
      end else if (d_neg[k]) begin
        ray_d[k] = 16'(-qc);
      end else begin
        ray_d[k] = qc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ray_q <= ray_d;
  end

  assign valid_o = valid_q;
  assign ray_x_o = ray_q[0];
  assign ray_y_o = ray_q[1];
  assign ray_z_o = ray_q[2];

endmodule

// ===== hw/rtl/prd_checker.sv =====
// Port-level checker for perspective_ray_direction, bound to the top level.
// Depends on prd_pkg.
`timescale 1ns / 1ps
module prd_checker import prd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic [15:0]       screen_u_i,
  input logic [15:0]       screen_v_i,
  input logic              valid_o,
  input logic signed [15:0] ray_x_o,
  input logic signed [15:0] ray_y_o,
  input logic signed [15:0] ray_z_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [AddrW-1:0]  paddr,
  input logic [DataW-1:0]  pwdata,
  input logic [DataW-1:0]  prdata,
  input logic              pready
);

  localparam int CW = $clog2(Latency + 2);
  logic [CW-1:0] age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
    end else if (age_q <= CW'(Latency)) begin
      age_q <= age_q + 1'b1;
    end
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (age_q > CW'(Latency)) |-> (valid_o == $past(start_i && !busy_o, Latency)))
    else $error("result strobe does not match transfer history");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (age_q < CW'(Latency)) |-> !valid_o)
    else $error("result strobe before pipeline could fill");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (ray_x_o >= -16'sd16384 && ray_x_o <= 16'sd16384 &&
                 ray_y_o >= -16'sd16384 && ray_y_o <= 16'sd16384 &&
                 ray_z_o >= -16'sd16384 && ray_z_o <= 16'sd16384))
    else $error("ray component outside unit range");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready) ##1 ($stable(paddr) && !(psel && penable && pwrite))
      |-> (prdata == 64'($past(pwdata) & 64'hFFFF_FFFF_FFFF) ||
           paddr[AddrW-1:3] == 2'd3))
    else $error("register read does not return last write");

endmodule

bind perspective_ray_direction prd_checker u_prd_checker (.*);

// ===== test/perspective_ray_direction_tb.sv =====
// Testbench for perspective_ray_direction: drives screen coordinates, writes the camera
// vectors over APB and checks every normalized ray against a fixed-point predictor.
// Depends on prd_pkg and the perspective_ray_direction RTL.
`timescale 1ns / 1ps
module perspective_ray_direction_tb;
  import prd_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } ray_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [15:0]       screen_u_i = '0;
  logic [15:0]       screen_v_i = '0;
  logic              valid_o;
  logic signed [15:0] ray_x_o, ray_y_o, ray_z_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  logic [RegW-1:0] corner_q, hstep_q, vstep_q;
  ray_t            ray_q[$];
  int              errors = 0;
  int              idle_cycles = 0;

  perspective_ray_direction uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint comp_of(logic [RegW-1:0] r, int k);
    return longint'($signed(r[CompBits*k +: CompBits]));
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic ray_t unit_ray(logic [15:0] u, logic [15:0] v);
    longint          d;
    longint unsigned mag[3];
    logic            neg[3];
    longint unsigned peak, sumsq, n, q;
    int              len;
    logic [15:0]     o[3];
    ray_t            r;
    peak = 0;
    sumsq = 0;
    for (int k = 0; k < 3; k++) begin
      d = comp_of(corner_q, k) * 32768 + longint'(u) * comp_of(hstep_q, k)
        + longint'(v) * comp_of(vstep_q, k);
      neg[k] = d < 0;
      mag[k] = neg[k] ? -d : d;
      if (mag[k] > peak) peak = mag[k];
    end
    if (peak == 0) begin
      r.x = '0;
      r.y = '0;
      r.z = '0;
      return r;
    end
    len = 0;
    while ((peak >> len) != 0) len++;
    for (int k = 0; k < 3; k++) begin
      if (len > MagW) mag[k] >>= (len - MagW);
      else mag[k] <<= (MagW - len);
      sumsq += mag[k] * mag[k];
    end
    n = root_floor(sumsq);
    for (int k = 0; k < 3; k++) begin
      q = (mag[k] * OutOne + (n >> 1)) / n;
      if (q > OutOne) q = OutOne;
      o[k] = neg[k] ? -q[15:0] : q[15:0];
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 3'b000});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegCorner: corner_q = val[RegW-1:0];
      RegHstep:  hstep_q = val[RegW-1:0];
      default:   vstep_q = val[RegW-1:0];
    endcase
  endtask

  task automatic set_camera(logic [DataW-1:0] c, logic [DataW-1:0] h, logic [DataW-1:0] v);
    start_i <= 1'b0;
    wait (ray_q.size() == 0);
    repeat (Latency + 4) @(posedge clk_i);
    write_reg(RegCorner, c);
    write_reg(RegHstep, h);
    write_reg(RegVstep, v);
  endtask

  task automatic send_coord(logic [15:0] u, logic [15:0] v, int gap);
    logic busy_seen;
    start_i <= 1'b1;
    screen_u_i <= u;
    screen_v_i <= v;
    do begin
      @(negedge clk_i);
      busy_seen = busy_o;
      @(posedge clk_i);
    end while (busy_seen);
    ray_q.push_back(unit_ray(u, v));
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return 16'd32768;
      2:       return 16'd0;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_vec();
    logic [DataW-1:0] w;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0)
      for (int k = 0; k < 3; k++) w[CompBits*k +: CompBits] = 16'($signed($urandom_range(0, 16384)) - 8192);
    return w;
  endfunction

  task automatic run_random(int count, bit bursty);
    for (int i = 0; i < count; i++)
      send_coord(rand_coord(), rand_coord(), bursty ? 0 : $urandom_range(0, 5));
  endtask

  task automatic test_zero_camera();
    send_coord(16'd0, 16'd0, 0);
    send_coord(16'hFFFF, 16'hFFFF, 1);
    send_coord(16'd32768, 16'd0, 0);
  endtask

  task automatic test_directed();
    logic [15:0] pts[6] = '{16'd0, 16'd1, 16'd16384, 16'd32768, 16'h7FFF, 16'hFFFF};
    set_camera({16'hFFFF, 16'h1000, 16'hE000, 16'hF000},
               {16'h0, 16'h0000, 16'h0000, 16'h2000},
               {16'h0, 16'h0000, 16'hE000, 16'h0000});
    foreach (pts[i]) send_coord(pts[i], pts[5 - i], $urandom_range(0, 2));
    send_coord(16'd16384, 16'd16384, 0);
    set_camera({16'h0, 16'h8000, 16'h8000, 16'h8000},
               {16'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF},
               {16'h0, 16'h7FFF, 16'h8000, 16'h7FFF});
    foreach (pts[i]) send_coord(pts[i], pts[i], 0);
    // corner cancels step exactly: zero-length sum
    set_camera({16'h0, 16'h0000, 16'hF000, 16'h0000},
               {16'h0, 16'h0000, 16'h2000, 16'h0000},
               {16'hABCD, 16'h0000, 16'h0000, 16'h0000});
    send_coord(16'd16384, 16'd0, 0);
    send_coord(16'd16384, 16'hFFFF, 0);
    send_coord(16'd0, 16'd0, 1);
  endtask

  task automatic test_random_scenes();
    for (int p = 0; p < 8; p++) begin
      set_camera(rand_vec(), rand_vec(), rand_vec());
      run_random(200, p % 3 == 0);
    end
  endtask

  task automatic test_extreme_regs();
    set_camera('1, '1, '1);
    run_random(60, 1'b0);
    set_camera({16'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF}, '0, '0);
    run_random(60, 1'b1);
    set_camera({16'h0, 16'h0000, 16'h0001, 16'h0000},
               {16'h0, 16'h8000, 16'h8000, 16'h8000},
               {16'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    run_random(80, 1'b0);
  endtask

  always @(posedge clk_i) begin
    ray_t e;
    if (valid_o) begin
      if (ray_q.size() == 0) begin
        $error("unexpected ray %0d %0d %0d", ray_x_o, ray_y_o, ray_z_o);
        errors++;
      end else begin
        e = ray_q.pop_front();
        if (ray_x_o !== e.x) begin
          $error("ray_x expected %0d actual %0d", e.x, ray_x_o);
          errors++;
        end
        if (ray_y_o !== e.y) begin
          $error("ray_y expected %0d actual %0d", e.y, ray_y_o);
          errors++;
        end
        if (ray_z_o !== e.z) begin
          $error("ray_z expected %0d actual %0d", e.z, ray_z_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    corner_q = '0;
    hstep_q = '0;
    vstep_q = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_camera();
    test_directed();
    test_random_scenes();
    test_extreme_regs();
    start_i <= 1'b0;
    wait (ray_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
